// ----- rtl/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types, constants and the restoring-division step of the colour
// converter pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned TdataW = 6 * ChanW;
  localparam int unsigned RemW   = 19;
  localparam int unsigned DivW   = 11;
  localparam int unsigned QuoW   = 9;
  localparam int unsigned SatRemW = 16;

  localparam logic KIND_RGB2HSV = 1'b0;
  localparam logic KIND_HSV2RGB = 1'b1;

  typedef enum logic [1:0] {
    STEP_HI  = 2'd0,
    STEP_MID = 2'd1,
    STEP_LO  = 2'd2
  } rhc_step_e;

  typedef struct packed {
    logic               kind;
    logic [RemW-1:0]    hue_rem;
    logic [DivW-1:0]    hue_div;
    logic [QuoW-1:0]    hue_q;
    logic [SatRemW-1:0] sat_rem;
    logic [ChanW-1:0]   sat_div;
    logic [QuoW-1:0]    sat_q;
    logic [ChanW-1:0]   rgb_max;
    logic [ChanW-1:0]   hsv_val;
    logic [15:0]        hsv_prod;
    logic [2:0]         hsv_sector;
    logic [8:0]         hsv_ramp;
    logic [ChanW-1:0]   hsv_c;
    logic [15:0]        hsv_cr;
    logic [ChanW-1:0]   hsv_red;
    logic [ChanW-1:0]   hsv_green;
    logic [ChanW-1:0]   hsv_blue;
  } rhc_pipe_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic            qbit;
  } rhc_div_res_t;

  // one restoring step: try subtracting dvs << sh
  function automatic rhc_div_res_t div_bit(logic [RemW-1:0] rem, logic [DivW-1:0] dvs,
                                           logic [3:0] sh);
    logic [RemW-1:0] trial;
    rhc_div_res_t    res;
    trial = RemW'(dvs) << sh;
    if (rem >= trial) begin
      res.rem  = rem - trial;
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

// ----- rtl/rgb_hsv_color_converter_core.sv -----
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter_core
// Pipelined 8-bit RGB <-> HSV colour converter.
// ----------------------------------------------------------------------------
// Input beat: tuser selects the direction (0 RGB to HSV, 1 HSV to RGB),
// tdata carries red, green, blue, hue, sat, val from bit 0 up.
// Output beat: tuser echoes the direction, tdata carries hue, sat, val,
// red, green, blue from bit 0 up; the fields of the other direction are 0.
// A beat passes through one set-up stage, three stages of the hue and
// saturation dividers (three quotient bits each) and the output register.
// Throughput is one beat per clock. Each stage advances when it is empty
// or the stage after it advances, so bubbles close up under a stall.
// A stalled output holds its beat; the input stalls only when all five
// stages are full and the output is not taken.
// Reset empties the pipeline; no beat is in flight after reset.
// ----------------------------------------------------------------------------
module rgb_hsv_color_converter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // red, green, blue, hue, sat, val
  input  logic [rhc_pkg::TdataW-1:0] s_axis_tdata_i,
  // req_type
  input  logic                       s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // res_hue, res_sat, res_val, res_red, res_green, res_blue
  output logic [rhc_pkg::TdataW-1:0] m_axis_tdata_o,
  // res_kind
  output logic                       m_axis_tuser_o
);

  rhc_pkg::rhc_pipe_t pipe1, pipe2, pipe3, pipe4;
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || m_axis_tready_i;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready_o = en1;

  rhc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (s_axis_tvalid_i),
    .kind_i  (s_axis_tuser_i),
    .data_i  (s_axis_tdata_i),
    .valid_o (v1),
    .pipe_o  (pipe1)
  );

  rhc_mid_stage u_stage_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (rhc_pkg::STEP_HI),
    .en_i    (en2),
    .valid_i (v1),
    .pipe_i  (pipe1),
    .valid_o (v2),
    .pipe_o  (pipe2)
  );

  rhc_mid_stage u_stage_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (rhc_pkg::STEP_MID),
    .en_i    (en3),
    .valid_i (v2),
    .pipe_i  (pipe2),
    .valid_o (v3),
    .pipe_o  (pipe3)
  );

  rhc_mid_stage u_stage_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (rhc_pkg::STEP_LO),
    .en_i    (en4),
    .valid_i (v3),
    .pipe_i  (pipe3),
    .valid_o (v4),
    .pipe_o  (pipe4)
  );

  rhc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en5),
    .valid_i (v4),
    .pipe_i  (pipe4),
    .valid_o (v5),
    .kind_o  (m_axis_tuser_o),
    .data_o  (m_axis_tdata_o)
  );

  assign m_axis_tvalid_o = v5;

endmodule

// ----- rtl/rhc_prep.sv -----
// ----------------------------------------------------------------------------
// rhc_prep
// First stage: max/min, hue numerator and divisor, saturation dividend,
// v*s product and hue sector/ramp.
// ----------------------------------------------------------------------------
module rhc_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic                       kind_i,
  input  logic [rhc_pkg::TdataW-1:0] data_i,
  output logic                       valid_o,
  output rhc_pkg::rhc_pipe_t         pipe_o
);

  logic [7:0]  red, green, blue, hue, sat, val;
  logic [7:0]  mx, mn, dif;
  logic [10:0] d2, d4, d6, num, ht;
  rhc_pkg::rhc_pipe_t pipe_d, pipe_q;
  logic valid_q;

  always_comb begin
    red   = data_i[7:0];
    green = data_i[15:8];
    blue  = data_i[23:16];
    hue   = data_i[31:24];
    sat   = data_i[39:32];
    val   = data_i[47:40];

    if (red >= green && red >= blue) begin
      mx = red;
    end else if (green >= blue) begin
      mx = green;
    end else begin
      mx = blue;
    end
    if (red <= green && red <= blue) begin
      mn = red;
    end else if (green <= blue) begin
      mn = green;
    end else begin
      mn = blue;
    end
    dif = mx - mn;
    d2  = {2'b0, dif, 1'b0};
    d4  = {1'b0, dif, 2'b0};
    d6  = d4 + d2;

    if (red >= green && red >= blue) begin
      num = d6 + 11'(green) - 11'(blue);
    end else if (green >= blue) begin
      num = d2 + 11'(blue) - 11'(red);
    end else begin
      num = d4 + 11'(red) - 11'(green);
    end

    ht = {1'b0, hue, 2'b0} + {2'b0, hue, 1'b0};

    pipe_d            = '0;
    pipe_d.kind       = kind_i;
    pipe_d.hue_rem    = {num, 8'b0};
    pipe_d.hue_div    = (dif == 8'd0) ? 11'd1 : d6;
    pipe_d.sat_rem    = {dif, 8'b0} - {8'b0, dif};
    pipe_d.sat_div    = (mx == 8'd0) ? 8'd1 : mx;
    pipe_d.rgb_max    = mx;
    pipe_d.hsv_val    = val;
    pipe_d.hsv_prod   = 16'(val) * 16'(sat);
    pipe_d.hsv_sector = ht[10:8];
    pipe_d.hsv_ramp   = ht[8] ? (9'd256 - {1'b0, ht[7:0]}) : {1'b0, ht[7:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// ----- rtl/rhc_mid_stage.sv -----
// ----------------------------------------------------------------------------
// rhc_mid_stage
// Middle stage: three quotient bits of both dividers plus one step of the
// HSV to RGB path, chosen by step_i.
// ----------------------------------------------------------------------------
module rhc_mid_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rhc_pkg::rhc_step_e        step_i,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rhc_pkg::rhc_pipe_t        pipe_i,
  output logic                      valid_o,
  output rhc_pkg::rhc_pipe_t        pipe_o
);

  rhc_pkg::rhc_pipe_t   pipe_d, pipe_q;
  rhc_pkg::rhc_div_res_t hres, sres;
  logic [3:0]  hi_bit, idx;
  logic [15:0] csum;
  logic [7:0]  xs, ms;
  logic        valid_q;

  always_comb begin
    pipe_d = pipe_i;
    case (step_i)
      rhc_pkg::STEP_HI:  hi_bit = 4'd8;
      rhc_pkg::STEP_MID: hi_bit = 4'd5;
      default:           hi_bit = 4'd2;
    endcase

    hres = '0;
    sres = '0;
    idx  = hi_bit;
    for (int k = 0; k < 3; k++) begin
      idx  = hi_bit - 4'(k);
      hres = rhc_pkg::div_bit(pipe_d.hue_rem, pipe_d.hue_div, idx);
      pipe_d.hue_rem    = hres.rem;
      pipe_d.hue_q[idx] = hres.qbit;
      sres = rhc_pkg::div_bit({3'b0, pipe_d.sat_rem}, {3'b0, pipe_d.sat_div}, idx);
      pipe_d.sat_rem    = sres.rem[rhc_pkg::SatRemW-1:0];
      pipe_d.sat_q[idx] = sres.qbit;
    end

    // floor(p/255) = (p + p/256 + 1) / 256 over 16 bits
    csum = pipe_i.hsv_prod + {8'b0, pipe_i.hsv_prod[15:8]} + 16'd1;
    xs   = pipe_i.hsv_cr[15:8];
    ms   = pipe_i.hsv_val - pipe_i.hsv_c;

    case (step_i)
      rhc_pkg::STEP_HI: begin
        pipe_d.hsv_c = csum[15:8];
      end
      rhc_pkg::STEP_MID: begin
        pipe_d.hsv_cr = {8'b0, pipe_i.hsv_c} * {7'b0, pipe_i.hsv_ramp};
      end
      default: begin
        case (pipe_i.hsv_sector)
          3'd0: begin
            pipe_d.hsv_red = pipe_i.hsv_c + ms; pipe_d.hsv_green = xs + ms;
            pipe_d.hsv_blue = ms;
          end
          3'd1: begin
            pipe_d.hsv_red = xs + ms; pipe_d.hsv_green = pipe_i.hsv_c + ms;
            pipe_d.hsv_blue = ms;
          end
          3'd2: begin
            pipe_d.hsv_red = ms; pipe_d.hsv_green = pipe_i.hsv_c + ms;
            pipe_d.hsv_blue = xs + ms;
          end
          3'd3: begin
            pipe_d.hsv_red = ms; pipe_d.hsv_green = xs + ms;
            pipe_d.hsv_blue = pipe_i.hsv_c + ms;
          end
          3'd4: begin
            pipe_d.hsv_red = xs + ms; pipe_d.hsv_green = ms;
            pipe_d.hsv_blue = pipe_i.hsv_c + ms;
          end
          default: begin
            pipe_d.hsv_red = pipe_i.hsv_c + ms; pipe_d.hsv_green = ms;
            pipe_d.hsv_blue = xs + ms;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// ----- rtl/rhc_out_stage.sv -----
// ----------------------------------------------------------------------------
// rhc_out_stage
// Output register: selects the fields of the requested direction and packs
// the result beat.
// ----------------------------------------------------------------------------
module rhc_out_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  rhc_pkg::rhc_pipe_t         pipe_i,
  output logic                       valid_o,
  output logic                       kind_o,
  output logic [rhc_pkg::TdataW-1:0] data_o
);

  logic [rhc_pkg::TdataW-1:0] data_d, data_q;
  logic kind_q, valid_q;

  always_comb begin
    if (pipe_i.kind == rhc_pkg::KIND_RGB2HSV) begin
      data_d = {24'b0, pipe_i.rgb_max, pipe_i.sat_q[7:0], pipe_i.hue_q[7:0]};
    end else begin
      data_d = {pipe_i.hsv_blue, pipe_i.hsv_green, pipe_i.hsv_red, 24'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      kind_q <= pipe_i.kind;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/rhc_checker.sv -----
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks of the colour converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic [rhc_pkg::TdataW-1:0] s_axis_tdata_i,
  input logic                       s_axis_tuser_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [rhc_pkg::TdataW-1:0] m_axis_tdata_o,
  input logic                       m_axis_tuser_o
);

  // input only backs up behind a stalled, full output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output back-pressure");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled output beat changed");

  a_hsv_zero_rgb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == rhc_pkg::KIND_RGB2HSV) |->
      m_axis_tdata_o[47:24] == 24'b0)
    else $error("rgb fields set on hsv result");

  a_rgb_zero_hsv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == rhc_pkg::KIND_HSV2RGB) |->
      m_axis_tdata_o[23:0] == 24'b0)
    else $error("hsv fields set on rgb result");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == rhc_pkg::KIND_RGB2HSV &&
     m_axis_tdata_o[23:16] == 8'd0) |-> m_axis_tdata_o[15:0] == 16'd0)
    else $error("black gave non-zero hue or saturation");

endmodule

bind rgb_hsv_color_converter_core rhc_checker u_rhc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ----- bench/rgb_hsv_color_converter_core_test.sv -----
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter_core_test
// Drives colour beats in both directions through the converter and checks
// every result beat, in order, against a bit-exact fixed-point model. Both
// stream sides idle and stall at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module rgb_hsv_color_converter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemCount   = 550;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    logic       kind;
    logic [7:0] red, green, blue, hue, sat, val;
  } colour_req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] hue, sat, val, red, green, blue;
  } colour_res_t;

  class colour_scoreboard;
    colour_res_t expected_colours[$];
    int unsigned mismatches;
    int unsigned beats_seen;

    function colour_res_t convert(colour_req_t req);
      colour_res_t res;
      int unsigned r, g, b, mx, mn, d, num;
      int unsigned c, t, sector, frac, ramp, x, m;
      res      = '0;
      res.kind = req.kind;
      if (req.kind == rhc_pkg::KIND_RGB2HSV) begin
        r  = req.red;
        g  = req.green;
        b  = req.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d       = mx - mn;
        res.val = 8'(mx);
        if (mx != 0) res.sat = 8'((d * 255) / mx);
        if (d != 0) begin
          if (mx == r) num = 6 * d + g - b;
          else if (mx == g) num = 2 * d + b - r;
          else num = 4 * d + r - g;
          res.hue = 8'((num * 256) / (6 * d));
        end
      end else begin
        c      = (int'(req.val) * int'(req.sat)) / 255;
        t      = int'(req.hue) * 6;
        sector = t >> 8;
        frac   = t & 255;
        ramp   = sector[0] ? 256 - frac : frac;
        x      = (c * ramp) >> 8;
        m      = int'(req.val) - c;
        case (sector)
          0: begin r = c; g = x; b = 0; end
          1: begin r = x; g = c; b = 0; end
          2: begin r = 0; g = c; b = x; end
          3: begin r = 0; g = x; b = c; end
          4: begin r = x; g = 0; b = c; end
          default: begin r = c; g = 0; b = x; end
        endcase
        res.red   = 8'(r + m);
        res.green = 8'(g + m);
        res.blue  = 8'(b + m);
      end
      return res;
    endfunction

    function void note_request(colour_req_t req);
      expected_colours.push_back(convert(req));
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      $display("%0t mismatch on %s at beat %0d: got %0d, want %0d",
               $realtime, what, beats_seen, got, want);
    endtask

    task compare_field(string what, int got, int want);
      if (got != want) report_mismatch(what, got, want);
    endtask

    task check_result(colour_res_t res);
      colour_res_t want;
      beats_seen++;
      if (expected_colours.size() == 0) begin
        report_mismatch("unexpected beat", int'(res.kind), 0);
      end else begin
        want = expected_colours.pop_front();
        compare_field("kind", int'(res.kind), int'(want.kind));
        compare_field("hue", int'(res.hue), int'(want.hue));
        compare_field("sat", int'(res.sat), int'(want.sat));
        compare_field("val", int'(res.val), int'(want.val));
        compare_field("red", int'(res.red), int'(want.red));
        compare_field("green", int'(res.green), int'(want.green));
        compare_field("blue", int'(res.blue), int'(want.blue));
      end
    endtask
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [rhc_pkg::TdataW-1:0] s_tdata = '0;
  logic                       s_tuser = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [rhc_pkg::TdataW-1:0] m_tdata;
  logic                       m_tuser;

  colour_scoreboard sb;
  bit               calm;
  int unsigned      stall_left;
  int unsigned      cycle_count;

  rgb_hsv_color_converter_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_length();
    int unsigned p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic colour_req_t make_rgb(int r, int g, int b);
    colour_req_t req;
    req       = colour_req_t'({$urandom, $urandom});
    req.kind  = rhc_pkg::KIND_RGB2HSV;
    req.red   = 8'(r);
    req.green = 8'(g);
    req.blue  = 8'(b);
    return req;
  endfunction

  function automatic colour_req_t make_hsv(int h, int s, int v);
    colour_req_t req;
    req      = colour_req_t'({$urandom, $urandom});
    req.kind = rhc_pkg::KIND_HSV2RGB;
    req.hue  = 8'(h);
    req.sat  = 8'(s);
    req.val  = 8'(v);
    return req;
  endfunction

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return 8'd254;
    endcase
  endfunction

  function automatic colour_req_t random_request();
    colour_req_t req;
    logic [7:0]  a, z;
    int unsigned mode;
    req  = colour_req_t'({$urandom, $urandom});
    mode = $urandom_range(0, 9);
    a    = 8'($urandom);
    z    = 8'($urandom_range(0, a));
    if (req.kind == rhc_pkg::KIND_RGB2HSV) begin
      case (mode)
        0: begin req.red = a; req.green = a; req.blue = a; end
        1: begin
          case ($urandom_range(0, 2))
            0: begin req.red = a; req.green = a; req.blue = z; end
            1: begin req.red = z; req.green = a; req.blue = a; end
            default: begin req.red = a; req.green = z; req.blue = a; end
          endcase
        end
        2: begin req.red = edge_byte(); req.green = edge_byte(); req.blue = edge_byte(); end
        default: ;
      endcase
    end else if (mode < 3) begin
      req.sat = edge_byte();
      req.val = edge_byte();
      if (mode == 0) req.hue = edge_byte();
    end
    return req;
  endfunction

  task automatic drive_colour(colour_req_t req);
    int unsigned gap;
    gap = idle_length();
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.kind;
    // red, green, blue, hue, sat, val from bit 0 up
    s_tdata  <= {req.val, req.sat, req.hue, req.blue, req.green, req.red};
    do @(posedge clk_i); while (!s_tready);
    sb.note_request(req);
  endtask

  // result side: random back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_length();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready)
      sb.check_result(colour_res_t'{kind: m_tuser, hue: m_tdata[7:0],
                                    sat: m_tdata[15:8], val: m_tdata[23:16],
                                    red: m_tdata[31:24], green: m_tdata[39:32],
                                    blue: m_tdata[47:40]});
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    sb = new;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // black, white, grey, primaries, ties, hue wrap just below red
    drive_colour(make_rgb(0, 0, 0));
    drive_colour(make_rgb(255, 255, 255));
    drive_colour(make_rgb(128, 128, 128));
    drive_colour(make_rgb(255, 0, 0));
    drive_colour(make_rgb(0, 255, 0));
    drive_colour(make_rgb(0, 0, 255));
    drive_colour(make_rgb(255, 255, 0));
    drive_colour(make_rgb(0, 255, 255));
    drive_colour(make_rgb(255, 0, 255));
    drive_colour(make_rgb(200, 200, 199));
    drive_colour(make_rgb(255, 0, 1));
    drive_colour(make_rgb(1, 0, 0));
    // sector edges, zero chroma, full scale
    drive_colour(make_hsv(0, 0, 0));
    drive_colour(make_hsv(255, 255, 255));
    drive_colour(make_hsv(0, 255, 255));
    drive_colour(make_hsv(42, 255, 255));
    drive_colour(make_hsv(43, 255, 255));
    drive_colour(make_hsv(85, 255, 200));
    drive_colour(make_hsv(128, 255, 255));
    drive_colour(make_hsv(171, 128, 255));
    drive_colour(make_hsv(213, 255, 255));
    drive_colour(make_hsv(100, 0, 255));
    drive_colour(make_hsv(200, 255, 0));
    drive_colour(make_hsv(255, 1, 1));

    for (int unsigned i = 0; i < ItemCount; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      drive_colour(random_request());
    end
    calm = 1'b0;
    @(negedge clk_i);
    s_tvalid <= 1'b0;

    while (sb.expected_colours.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_colours.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
